// ----- src/mgrf_pkg.sv -----
// Shared types and constants for the get-reply framer.
// Holds the phase encoding, the classified word and the protocol characters.
`timescale 1ns / 1ps
`default_nettype none
package mgrf_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_V  = 8'h56;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  // Positions in the END CRLF line
  localparam logic [2:0] EM_N  = 3'd1;
  localparam logic [2:0] EM_D  = 3'd2;
  localparam logic [2:0] EM_CR = 3'd3;
  localparam logic [2:0] EM_LF = 3'd4;

  typedef enum logic [2:0] {
    PH_LINE = 3'd0,
    PH_HEAD = 3'd1,
    PH_LEN  = 3'd2,
    PH_TAIL = 3'd3,
    PH_BODY = 3'd4,
    PH_CR   = 3'd5,
    PH_LF   = 3'd6,
    PH_END  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
    logic       is_v;
    logic       is_e;
    logic       is_n;
    logic       is_d;
  } cls_t;

endpackage
`default_nettype wire

// ----- src/memcache_get_reply_framer.sv -----
// Get-reply framer for a memcached-style text backend stream.
// Usage:
//   Input channel: data_byte and is_last_backend, with in_valid/in_ready.
//   Output channel: out_byte, forward, reply_done, parse_error, with
//   out_valid/out_ready. Every input byte yields exactly one output word.
//   VALUE headers and bodies are forwarded; END lines are forwarded only
//   when is_last_backend is set, and their final LF raises reply_done.
//   A malformed line or a body length of 2^LENGTH_BITS or more raises
//   parse_error on the offending byte, which is dropped.
// Timing:
//   A byte accepted into the queue passes on to the output register, where
//   out_valid rises. Throughput is one byte per cycle while out_ready stays
//   high, set by the parser state update.
//   A 2-word queue decouples the classifier from the parser, so in_ready
//   stays high while a result waits in the output register, until the queue fills.
// Reset (rst, synchronous): parser returns to line start, queue and
//   output register empty. When the receiver stalls, the output register
//   holds, the queue fills, and in_ready drops once it is full.
// Depends on mgrf_pkg, mgrf_classify, mgrf_queue and mgrf_parse.
`timescale 1ns / 1ps
`default_nettype none
module memcache_get_reply_framer #(
  parameter int LENGTH_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       is_last_backend,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            forward,
  output logic            reply_done,
  output logic            parse_error
);
  import mgrf_pkg::*;

  cls_t in_word;
  cls_t q_word;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  mgrf_classify u_classify (
    .data_byte       (data_byte),
    .is_last_backend (is_last_backend),
    .word            (in_word)
  );

  mgrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (in_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_word)
  );

  mgrf_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .forward     (forward),
    .reply_done  (reply_done),
    .parse_error (parse_error)
  );

endmodule
`default_nettype wire

// ----- src/mgrf_classify.sv -----
// Front end: tags input bytes with their character class.
// Depends on mgrf_pkg for cls_t and the character constants.
`timescale 1ns / 1ps
`default_nettype none
module mgrf_classify (
  input  wire logic [7:0]    data_byte,
  input  wire logic          is_last_backend,
  output mgrf_pkg::cls_t     word
);
  import mgrf_pkg::*;

  always_comb begin
    word.byte_val = data_byte;
    word.last     = is_last_backend;
    word.is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
    word.digit    = data_byte[3:0];
    word.is_space = (data_byte == CH_SP);
    word.is_cr    = (data_byte == CH_CR);
    word.is_lf    = (data_byte == CH_LF);
    word.is_v     = (data_byte == CH_V);
    word.is_e     = (data_byte == CH_E);
    word.is_n     = (data_byte == CH_N);
    word.is_d     = (data_byte == CH_D);
  end

endmodule
`default_nettype wire

// ----- src/mgrf_queue.sv -----
// Short queue of classified words between the front end and the parser.
// Depends on mgrf_pkg for cls_t and the queue depth.
`timescale 1ns / 1ps
`default_nettype none
module mgrf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mgrf_pkg::cls_t push_word,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output mgrf_pkg::cls_t      head
);
  import mgrf_pkg::*;

  cls_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/mgrf_parse.sv -----
// Back end: line parser state machine and the output register.
// Depends on mgrf_pkg for phase_t, cls_t and the END line positions.
`timescale 1ns / 1ps
`default_nettype none
module mgrf_parse #(
  parameter int LENGTH_BITS = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire mgrf_pkg::cls_t q_word,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               forward,
  output logic               reply_done,
  output logic               parse_error
);
  import mgrf_pkg::*;

  localparam int PW = LENGTH_BITS + 4;

  phase_t                 phase, phase_next;
  logic [1:0]             space_count, space_count_next;
  logic [LENGTH_BITS-1:0] body_length, body_length_next;
  logic [2:0]             end_match_index, end_match_index_next;

  logic [PW-1:0]          acc;
  logic [LENGTH_BITS-1:0] body_dec;
  logic                   end_hit;
  logic                   fwd, done, err;

  assign pop = q_valid && (!out_valid || out_ready);

  // body * 10 + digit, as shifts and adds
  assign acc = PW'({body_length, 3'b000}) + PW'({body_length, 1'b0}) + PW'(q_word.digit);
  assign body_dec = body_length - 1'b1;

  always_comb begin
    case (end_match_index)
      EM_N:    end_hit = q_word.is_n;
      EM_D:    end_hit = q_word.is_d;
      EM_CR:   end_hit = q_word.is_cr;
      EM_LF:   end_hit = q_word.is_lf;
      default: end_hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    space_count_next     = space_count;
    body_length_next     = body_length;
    end_match_index_next = end_match_index;
    fwd  = 1'b1;
    done = 1'b0;
    err  = 1'b0;
    case (phase)
      PH_HEAD: begin
        if (q_word.is_space) begin
          space_count_next = space_count + 1'b1;
          if (space_count == 2'd2) begin
            phase_next           = PH_LEN;
            body_length_next     = '0;
            end_match_index_next = '0;
          end
        end else if (q_word.is_lf) begin
          err = 1'b1;
        end
      end
      PH_LEN: begin
        if (q_word.is_digit) begin
          if (acc[PW-1:LENGTH_BITS] != '0) begin
            err = 1'b1;
          end else begin
            body_length_next     = acc[LENGTH_BITS-1:0];
            end_match_index_next = 3'd1;
          end
        end else if (end_match_index == '0) begin
          err = 1'b1;
        end else if (q_word.is_space || q_word.is_cr) begin
          phase_next = PH_TAIL;
        end else if (q_word.is_lf) begin
          phase_next = (body_length == '0) ? PH_CR : PH_BODY;
        end else begin
          err = 1'b1;
        end
      end
      PH_TAIL: begin
        if (q_word.is_lf) begin
          phase_next = (body_length == '0) ? PH_CR : PH_BODY;
        end
      end
      PH_BODY: begin
        body_length_next = body_dec;
        if (body_dec == '0) begin
          phase_next = PH_CR;
        end
      end
      PH_CR: begin
        if (q_word.is_cr) phase_next = PH_LF;
        else              err = 1'b1;
      end
      PH_LF: begin
        if (q_word.is_lf) phase_next = PH_LINE;
        else              err = 1'b1;
      end
      PH_END: begin
        if (end_hit) begin
          fwd = q_word.last;
          if (end_match_index == EM_LF) begin
            done                 = 1'b1;
            phase_next           = PH_LINE;
            end_match_index_next = '0;
          end else begin
            end_match_index_next = end_match_index + 1'b1;
          end
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (q_word.is_v) begin
          phase_next           = PH_HEAD;
          space_count_next     = '0;
          body_length_next     = '0;
          end_match_index_next = '0;
        end else if (q_word.is_e) begin
          phase_next           = PH_END;
          end_match_index_next = EM_N;
          fwd                  = q_word.last;
        end else begin
          err = 1'b1;
        end
      end
    endcase
    // drop the byte and return to line start
    if (err) begin
      fwd                  = 1'b0;
      phase_next           = PH_LINE;
      space_count_next     = '0;
      body_length_next     = '0;
      end_match_index_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LINE;
      space_count     <= '0;
      body_length     <= '0;
      end_match_index <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        space_count     <= space_count_next;
        body_length     <= body_length_next;
        end_match_index <= end_match_index_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte    <= q_word.byte_val;
      forward     <= fwd;
      reply_done  <= done;
      parse_error <= err;
    end
  end

`ifndef SYNTHESIS
  a_done_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reply_done && parse_error))
    else $error("reply_done and parse_error raised together");

  a_err_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_error |-> !forward)
    else $error("error word forwarded");

  a_err_restarts: assert property (@(posedge clk) disable iff (rst)
    pop && err |=> phase == PH_LINE && body_length == '0 && end_match_index == '0)
    else $error("parser state not cleared after error");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> body_length != '0)
    else $error("body phase with zero remaining length");

  a_done_at_line: assert property (@(posedge clk) disable iff (rst)
    pop && done |=> phase == PH_LINE)
    else $error("done without return to line start");
`endif

endmodule
`default_nettype wire
